>>> design/space_vector_pwm_modulator_assert.svh
// assertion macros for the space vector pwm modulator
// no dependencies; included by the top level only
`ifndef SPACE_VECTOR_PWM_MODULATOR_ASSERT_SVH
`define SPACE_VECTOR_PWM_MODULATOR_ASSERT_SVH
`ifndef SYNTH
`define SVPM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svpm assertion failed");
`define SVPM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("svpm assertion failed");
`else
`define SVPM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SVPM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/svpm_pkg.sv
// shared widths, codes, tables and types of the space vector pwm modulator
// no dependencies
`timescale 1ns / 1ps
package svpm_pkg;
   localparam int COMPARE_BITS_DEF    = 12;
   localparam int ANGLE_FRAC_BITS_DEF = 7;
   localparam int CORDIC_STEPS        = 16;
   localparam int PHASE_W    = 8;
   localparam int COMPARE_W  = 12;
   localparam int SECTOR_W   = 3;
   localparam int MI_W       = 10;
   localparam int DS_W       = 8;
   localparam int GAIN_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int VEC_W      = 27;
   localparam int ARG_W      = 22;
   localparam int ROT_ZW     = 24;
   localparam int ROT_W      = 18;
   localparam int SINE_W     = 15;
   localparam int DWELL_W    = 16;
   localparam int SUM_W      = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int ANG_ONE         = 65536;
   localparam int SQRT3_Q14       = 28378;
   localparam int CORDIC_INV_GAIN = 9949;
   localparam int SINE_ONE        = 16384;

   typedef logic [SECTOR_W-1:0] sector_type;
   localparam sector_type SEC_ONE   = 3'd0;
   localparam sector_type SEC_TWO   = 3'd1;
   localparam sector_type SEC_THREE = 3'd2;
   localparam sector_type SEC_FOUR  = 3'd3;
   localparam sector_type SEC_FIVE  = 3'd4;
   localparam sector_type SEC_SIX   = 3'd5;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_MOD_INDEX   = 3'd0;
   localparam csr_index_type CSR_DWELL_SCALE = 3'd1;
   localparam csr_index_type CSR_GAIN_FIRST  = 3'd2;
   localparam csr_index_type CSR_GAIN_SECOND = 3'd3;
   localparam csr_index_type CSR_GAIN_THIRD  = 3'd4;

   localparam logic [MI_W-1:0]   MI_RESET = 10'd819;
   localparam logic [DS_W-1:0]   DS_RESET = 8'd40;
   localparam logic [GAIN_W-1:0] G1_RESET = 12'd384;
   localparam logic [GAIN_W-1:0] G2_RESET = 12'd1690;
   localparam logic [GAIN_W-1:0] G3_RESET = 12'd1792;

   // atan(2^-i) in 2^-16 degree
   localparam logic signed [VEC_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
      27'sd234379, 27'sd117304, 27'sd58666, 27'sd29335,
      27'sd14668, 27'sd7334, 27'sd3667, 27'sd1833,
      27'sd917, 27'sd458, 27'sd229, 27'sd115};

   typedef struct packed {
      logic [MI_W-1:0]   mod_index;
      logic [DS_W-1:0]   dwell_scale;
      logic [GAIN_W-1:0] gain_first;
      logic [GAIN_W-1:0] gain_second;
      logic [GAIN_W-1:0] gain_third;
   } cfg_type;

   typedef struct packed {
      sector_type       sector;
      logic [ARG_W-1:0] arg_first;
      logic [ARG_W-1:0] arg_second;
   } job_type;
endpackage

>>> design/svpm_req_if.sv
// reference sample channel: valid, ready and the three phase samples
// depends on svpm_pkg
`timescale 1ns / 1ps
interface svpm_req_if;
   logic                      valid;
   logic                      ready;
   logic [svpm_pkg::PHASE_W-1:0] phase_a_ref;
   logic [svpm_pkg::PHASE_W-1:0] phase_b_ref;
   logic [svpm_pkg::PHASE_W-1:0] phase_c_ref;
   modport source (output valid, phase_a_ref, phase_b_ref, phase_c_ref, input ready);
   modport sink (input valid, phase_a_ref, phase_b_ref, phase_c_ref, output ready);
endinterface

>>> design/svpm_rsp_if.sv
// compare value channel: valid, ready, three compares and the sector
// depends on svpm_pkg
`timescale 1ns / 1ps
interface svpm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [svpm_pkg::COMPARE_W-1:0] compare_first;
   logic [svpm_pkg::COMPARE_W-1:0] compare_second;
   logic [svpm_pkg::COMPARE_W-1:0] compare_third;
   logic [svpm_pkg::SECTOR_W-1:0]  sector_index;
   modport source (output valid, compare_first, compare_second, compare_third,
      sector_index, input ready);
   modport sink (input valid, compare_first, compare_second, compare_third,
      sector_index, output ready);
endinterface

>>> design/svpm_csr_if.sv
// register write channel: valid, ready, register index and data
// depends on svpm_pkg
`timescale 1ns / 1ps
interface svpm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [svpm_pkg::CSR_IDX_W-1:0]  index;
   logic [svpm_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/svpm_front.sv
// front part: sector classification, vectoring cordic pipeline, in-sector angle
// depends on svpm_pkg and svpm_req_if
`timescale 1ns / 1ps
module svpm_front #(
   parameter int ANGLE_FRAC_BITS = svpm_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   svpm_req_if.sink          req,
   output logic              push,
   output svpm_pkg::job_type push_job,
   input  logic              push_ready
);
   import svpm_pkg::*;
   localparam int SHIFT = 16 - ANGLE_FRAC_BITS;
   localparam int LAST  = CORDIC_STEPS + 1;
   localparam logic signed [VEC_W-1:0] HALF      = VEC_W'(2 ** (SHIFT - 1));
   localparam logic signed [VEC_W-1:0] SIXTY     = VEC_W'(60 * 2 ** ANGLE_FRAC_BITS);
   localparam logic signed [VEC_W-1:0] HALF_TURN = VEC_W'(180 * ANG_ONE);
   localparam logic signed [VEC_W-1:0] SQRT3     = VEC_W'(SQRT3_Q14);

   function automatic logic signed [9:0] sector_base(input sector_type s);
      case (s)
         SEC_ONE:   return 10'sd0;
         SEC_TWO:   return 10'sd60;
         SEC_THREE: return 10'sd120;
         SEC_FOUR:  return -10'sd180;
         SEC_FIVE:  return -10'sd120;
         default:   return -10'sd60;
      endcase
   endfunction

   logic adv;
   logic accept;
   logic [LAST:0] vld_ff;
   logic signed [VEC_W-1:0] px_ff [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0] py_ff [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0] z_ff  [0:CORDIC_STEPS];
   sector_type sec_ff [0:CORDIC_STEPS];
   logic zero_ff [0:CORDIC_STEPS];
   job_type job_ff, job_in;

   logic signed [9:0] x_val, nx_val, u_val;
   logic signed [VEC_W-1:0] px0, py0, z0;
   sector_type sec0;
   logic signed [VEC_W-1:0] zs, ang, phi, phi_c, arg1, arg2;

   assign adv       = !vld_ff[LAST] || push_ready;
   assign accept    = req.valid && adv;
   assign req.ready = adv;
   assign push      = vld_ff[LAST] && push_ready;
   assign push_job  = job_ff;

   // x = 2a - b - c, u = b - c
   always_comb begin
      x_val  = $signed({1'b0, req.phase_a_ref, 1'b0}) - $signed({2'b0, req.phase_b_ref})
             - $signed({2'b0, req.phase_c_ref});
      u_val  = $signed({2'b0, req.phase_b_ref}) - $signed({2'b0, req.phase_c_ref});
      nx_val = -x_val;
      if (u_val > 0 && u_val <= x_val) begin
         sec0 = SEC_ONE;
      end else if (u_val > x_val && u_val >= nx_val) begin
         sec0 = SEC_TWO;
      end else if (u_val >= 0 && u_val < nx_val) begin
         sec0 = SEC_THREE;
      end else if (u_val < 0 && u_val >= x_val) begin
         sec0 = SEC_FOUR;
      end else if (u_val < x_val && u_val <= nx_val) begin
         sec0 = SEC_FIVE;
      end else begin
         sec0 = SEC_SIX;
      end
      px0 = VEC_W'(x_val) <<< 14;
      py0 = VEC_W'(u_val) * SQRT3;
      z0  = '0;
      // fold the left half plane onto the right
      if (x_val < 0) begin
         z0  = (u_val >= 0) ? HALF_TURN : -HALF_TURN;
         px0 = -px0;
         py0 = -py0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff[0]   <= px0;
         py_ff[0]   <= py0;
         z_ff[0]    <= z0;
         sec_ff[0]  <= sec0;
         zero_ff[0] <= (x_val == 0) && (u_val == 0);
         job_ff     <= job_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!py_ff[i][VEC_W-1]) begin
               px_ff[i+1] <= px_ff[i] + (py_ff[i] >>> i);
               py_ff[i+1] <= py_ff[i] - (px_ff[i] >>> i);
               z_ff[i+1]  <= z_ff[i] + ATAN_TABLE[i];
            end else begin
               px_ff[i+1] <= px_ff[i] - (py_ff[i] >>> i);
               py_ff[i+1] <= py_ff[i] + (px_ff[i] >>> i);
               z_ff[i+1]  <= z_ff[i] - ATAN_TABLE[i];
            end
            sec_ff[i+1]  <= sec_ff[i];
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // round the angle, take the in-sector angle and clamp it
   always_comb begin
      zs  = zero_ff[CORDIC_STEPS] ? '0 : z_ff[CORDIC_STEPS];
      ang = (zs + HALF) >>> SHIFT;
      phi = ang - (VEC_W'(sector_base(sec_ff[CORDIC_STEPS])) <<< ANGLE_FRAC_BITS);
      if (phi < 0) begin
         phi_c = '0;
      end else if (phi > SIXTY) begin
         phi_c = SIXTY;
      end else begin
         phi_c = phi;
      end
      arg1 = (SIXTY - phi_c) <<< SHIFT;
      arg2 = phi_c <<< SHIFT;
      job_in.sector     = sec_ff[CORDIC_STEPS];
      job_in.arg_first  = arg1[ARG_W-1:0];
      job_in.arg_second = arg2[ARG_W-1:0];
   end
endmodule

>>> design/svpm_queue.sv
// short queue between the front and back parts
// depends on svpm_pkg
`timescale 1ns / 1ps
module svpm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  svpm_pkg::job_type push_job,
   output logic              push_ready,
   output logic              pop_valid,
   output svpm_pkg::job_type pop_job,
   input  logic              pop
);
   import svpm_pkg::*;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0] count_ff;
   logic do_pop;

   assign push_ready = (count_ff != (PTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ff];
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_W + 1)'(push) - (PTR_W + 1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end
endmodule

>>> design/svpm_back.sv
// back part: two sine cordic pipelines, dwell products, sector rules, gains
// depends on svpm_pkg and svpm_rsp_if
`timescale 1ns / 1ps
module svpm_back #(
   parameter int COMPARE_BITS = svpm_pkg::COMPARE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  svpm_pkg::cfg_type cfg,
   input  logic              pop_valid,
   input  svpm_pkg::job_type pop_job,
   output logic              pop,
   svpm_rsp_if.source        rsp
);
   import svpm_pkg::*;
   localparam int LAST = CORDIC_STEPS + 5;
   localparam int MUL = CORDIC_STEPS + 1;
   localparam int TOP = 2 ** COMPARE_BITS - 1;
   localparam int M1_W = MI_W + SINE_W;
   localparam int M2_W = M1_W + DS_W;
   localparam int P_W  = SUM_W + GAIN_W;

   logic adv;
   logic [LAST:0] vld_ff;
   sector_type sec_ff [0:LAST-1];
   logic signed [ROT_W-1:0]  ax_ff [0:CORDIC_STEPS];
   logic signed [ROT_W-1:0]  ay_ff [0:CORDIC_STEPS];
   logic signed [ROT_ZW-1:0] az_ff [0:CORDIC_STEPS];
   logic signed [ROT_W-1:0]  bx_ff [0:CORDIC_STEPS];
   logic signed [ROT_W-1:0]  by_ff [0:CORDIC_STEPS];
   logic signed [ROT_ZW-1:0] bz_ff [0:CORDIC_STEPS];
   logic [M1_W-1:0] m1a_ff, m1b_ff;
   logic [M2_W-1:0] m2a_ff, m2b_ff;
   logic [DWELL_W-1:0] t1_ff, t2_ff, t1_in, t2_in;
   logic [P_W-1:0] p1_ff, p2_ff, p3_ff;
   logic [SUM_W-1:0] s1, s2, s3, tsum;
   logic [SINE_W-1:0] sa, sb;
   logic [COMPARE_W-1:0] c1_ff, c2_ff, c3_ff, c1_in, c2_in, c3_in;
   sector_type sec_out_ff;

   function automatic logic [SINE_W-1:0] clamp_sine(input logic signed [ROT_W-1:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > ROT_W'(SINE_ONE)) begin
         return SINE_W'(SINE_ONE);
      end else begin
         return v[SINE_W-1:0];
      end
   endfunction

   function automatic logic [DWELL_W-1:0] round_dwell(input logic [M2_W-1:0] v);
      logic [M2_W-1:0] r;
      r = (v + M2_W'(8192)) >> 14;
      return (r > M2_W'(65535)) ? DWELL_W'(65535) : r[DWELL_W-1:0];
   endfunction

   function automatic logic [COMPARE_W-1:0] sat_compare(input logic [P_W-1:0] p);
      logic [P_W-19:0] v;
      v = p[P_W-1:18];
      return (32'(v) > TOP) ? COMPARE_W'(TOP) : COMPARE_W'(v);
   endfunction

   assign adv = !vld_ff[LAST] || rsp.ready;
   assign pop = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], pop_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff[0]  <= ROT_W'(CORDIC_INV_GAIN);
         ay_ff[0]  <= '0;
         az_ff[0]  <= ROT_ZW'(pop_job.arg_first);
         bx_ff[0]  <= ROT_W'(CORDIC_INV_GAIN);
         by_ff[0]  <= '0;
         bz_ff[0]  <= ROT_ZW'(pop_job.arg_second);
         sec_ff[0] <= pop_job.sector;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!az_ff[i][ROT_ZW-1]) begin
               ax_ff[i+1] <= ax_ff[i] - (ay_ff[i] >>> i);
               ay_ff[i+1] <= ay_ff[i] + (ax_ff[i] >>> i);
               az_ff[i+1] <= az_ff[i] - ROT_ZW'(ATAN_TABLE[i]);
            end else begin
               ax_ff[i+1] <= ax_ff[i] + (ay_ff[i] >>> i);
               ay_ff[i+1] <= ay_ff[i] - (ax_ff[i] >>> i);
               az_ff[i+1] <= az_ff[i] + ROT_ZW'(ATAN_TABLE[i]);
            end
            if (!bz_ff[i][ROT_ZW-1]) begin
               bx_ff[i+1] <= bx_ff[i] - (by_ff[i] >>> i);
               by_ff[i+1] <= by_ff[i] + (bx_ff[i] >>> i);
               bz_ff[i+1] <= bz_ff[i] - ROT_ZW'(ATAN_TABLE[i]);
            end else begin
               bx_ff[i+1] <= bx_ff[i] + (by_ff[i] >>> i);
               by_ff[i+1] <= by_ff[i] - (bx_ff[i] >>> i);
               bz_ff[i+1] <= bz_ff[i] + ROT_ZW'(ATAN_TABLE[i]);
            end
         end
      end
   end

   for (genvar j = 1; j < LAST; j++) begin : g_sec
      always_ff @(posedge clock) begin
         if (adv) begin
            sec_ff[j] <= sec_ff[j-1];
         end
      end
   end

   always_comb begin
      sa    = clamp_sine(ay_ff[CORDIC_STEPS]);
      sb    = clamp_sine(by_ff[CORDIC_STEPS]);
      t1_in = round_dwell(m2a_ff);
      t2_in = round_dwell(m2b_ff);
      tsum  = SUM_W'(t1_ff) + SUM_W'(t2_ff);
      case (sec_ff[MUL+2])
         SEC_ONE: begin
            s1 = tsum; s2 = SUM_W'(t2_ff); s3 = '0;
         end
         SEC_TWO: begin
            s1 = SUM_W'(t1_ff); s2 = tsum; s3 = '0;
         end
         SEC_THREE: begin
            s1 = '0; s2 = tsum; s3 = SUM_W'(t2_ff);
         end
         SEC_FOUR: begin
            s1 = '0; s2 = SUM_W'(t1_ff); s3 = tsum;
         end
         SEC_FIVE: begin
            s1 = SUM_W'(t2_ff); s2 = '0; s3 = tsum;
         end
         default: begin
            s1 = tsum; s2 = '0; s3 = SUM_W'(t1_ff);
         end
      endcase
      c1_in = sat_compare(p1_ff);
      c2_in = sat_compare(p2_ff);
      c3_in = sat_compare(p3_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1a_ff     <= M1_W'(cfg.mod_index) * M1_W'(sa);
         m1b_ff     <= M1_W'(cfg.mod_index) * M1_W'(sb);
         m2a_ff     <= M2_W'(m1a_ff) * M2_W'(cfg.dwell_scale);
         m2b_ff     <= M2_W'(m1b_ff) * M2_W'(cfg.dwell_scale);
         t1_ff      <= t1_in;
         t2_ff      <= t2_in;
         p1_ff      <= P_W'(s1) * P_W'(cfg.gain_first);
         p2_ff      <= P_W'(s2) * P_W'(cfg.gain_second);
         p3_ff      <= P_W'(s3) * P_W'(cfg.gain_third);
         c1_ff      <= c1_in;
         c2_ff      <= c2_in;
         c3_ff      <= c3_in;
         sec_out_ff <= sec_ff[LAST-1];
      end
   end

   assign rsp.valid          = vld_ff[LAST];
   assign rsp.compare_first  = c1_ff;
   assign rsp.compare_second = c2_ff;
   assign rsp.compare_third  = c3_ff;
   assign rsp.sector_index   = sec_out_ff;
endmodule

>>> design/space_vector_pwm_modulator.sv
// top level of the space vector pwm modulator: registers, front, queue, back
// depends on svpm_pkg, the channel interfaces, svpm_front, svpm_queue, svpm_back
//
// channel   modport  transaction
// req_ch    sink     one reference triple phase_a_ref, phase_b_ref, phase_c_ref
// rsp_ch    source   three compare values and sector_index
// csr_ch    sink     one register write, index and data, always ready
//
// one triple enters per cycle unless back-pressure from the output fills the queue
// the path holds the 16-stage cordic pipelines, front and back, and the multiply stages
// reset clears the valid bits, queue pointers and registers to their defaults
// a stalled output holds the back pipeline; the 4-entry queue lets the front keep going
`timescale 1ns / 1ps
`include "space_vector_pwm_modulator_assert.svh"
module space_vector_pwm_modulator #(
   parameter int COMPARE_BITS    = svpm_pkg::COMPARE_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = svpm_pkg::ANGLE_FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   svpm_req_if.sink   req_ch,
   svpm_rsp_if.source rsp_ch,
   svpm_csr_if.sink   csr_ch
);
   import svpm_pkg::*;

   cfg_type cfg_ff;
   logic push, push_ready, pop_valid, pop;
   job_type push_job, pop_job;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mod_index   <= MI_RESET;
         cfg_ff.dwell_scale <= DS_RESET;
         cfg_ff.gain_first  <= G1_RESET;
         cfg_ff.gain_second <= G2_RESET;
         cfg_ff.gain_third  <= G3_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MOD_INDEX:   cfg_ff.mod_index   <= csr_ch.data[MI_W-1:0];
            CSR_DWELL_SCALE: cfg_ff.dwell_scale <= csr_ch.data[DS_W-1:0];
            CSR_GAIN_FIRST:  cfg_ff.gain_first  <= csr_ch.data[GAIN_W-1:0];
            CSR_GAIN_SECOND: cfg_ff.gain_second <= csr_ch.data[GAIN_W-1:0];
            CSR_GAIN_THIRD:  cfg_ff.gain_third  <= csr_ch.data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   svpm_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .req(req_ch),
      .push(push), .push_job(push_job), .push_ready(push_ready));

   svpm_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job),
      .push_ready(push_ready), .pop_valid(pop_valid), .pop_job(pop_job), .pop(pop));

   svpm_back #(.COMPARE_BITS(COMPARE_BITS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .pop_valid(pop_valid),
      .pop_job(pop_job), .pop(pop), .rsp(rsp_ch));

   // sector rules leave one channel at zero
   `SVPM_ASSERT_IMP(a_third_idle, clock, reset, rsp_ch.valid && (rsp_ch.sector_index == SEC_ONE || rsp_ch.sector_index == SEC_TWO), rsp_ch.compare_third == '0)
   `SVPM_ASSERT_IMP(a_first_idle, clock, reset, rsp_ch.valid && (rsp_ch.sector_index == SEC_THREE || rsp_ch.sector_index == SEC_FOUR), rsp_ch.compare_first == '0)
   `SVPM_ASSERT_IMP(a_second_idle, clock, reset, rsp_ch.valid && (rsp_ch.sector_index == SEC_FIVE || rsp_ch.sector_index == SEC_SIX), rsp_ch.compare_second == '0)
   `SVPM_ASSERT_NXT(a_mi_write, clock, reset, csr_ch.valid && csr_ch.index == CSR_MOD_INDEX, cfg_ff.mod_index == $past(csr_ch.data[MI_W-1:0]))
endmodule
